### hw/rtl/mbg_pkg.sv
// Package with the types, constants and helpers of the metronome beat generator.
`timescale 1ns / 1ps
`default_nettype none
package mbg_pkg;

  localparam int TIME_W     = 32;
  localparam int TICK_W     = 16;
  localparam int TEMPO_W    = 8;
  localparam int BAR_W      = 4;
  localparam int PULSE_W    = 8;
  localparam int DIVIDEND_W = TICK_W + 6;
  localparam int DIVISOR_W  = TICK_W + 2;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int PERIOD_W   = DIVIDEND_W;
  localparam int ADDR_W     = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_TAP    = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_SET    = 2'd3
  } mbg_op_t;

  typedef enum logic [1:0] {
    REG_BEATS_PER_BAR = 2'd0,
    REG_TICK_RATE     = 2'd1,
    REG_ACCENT_PULSE  = 2'd2,
    REG_BEAT_PULSE    = 2'd3
  } mbg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP_DIV,
    ST_PER_DIV
  } mbg_state_t;

  typedef struct packed {
    logic [BAR_W-1:0]   beats_left;
    logic               running;
    logic [TEMPO_W-1:0] tempo_now;
    logic [PULSE_W-1:0] pulse_ms;
    logic               accent;
    logic               beat;
  } mbg_result_t;

  localparam logic [BAR_W-1:0]    RST_BEATS_PER_BAR = 4'd4;
  localparam logic [TICK_W-1:0]   RST_TICK_RATE     = 16'd1024;
  localparam logic [PULSE_W-1:0]  RST_ACCENT_PULSE  = 8'd90;
  localparam logic [PULSE_W-1:0]  RST_BEAT_PULSE    = 8'd30;
  localparam logic [PERIOD_W-1:0] RST_PERIOD        = PERIOD_W'(512);
  localparam logic [TEMPO_W-1:0]  RST_TEMPO         = 8'd120;
  localparam logic [TEMPO_W-1:0]  TEMPO_MAX         = 8'd255;

  // Ticks in one minute: rate * 60 as (rate << 6) - (rate << 2).
  function automatic logic [DIVIDEND_W-1:0] ticks_per_min(input logic [TICK_W-1:0] rate);
    return {rate, 6'b0} - {4'b0, rate, 2'b0};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/metronome_beat_generator_core.sv
// Top level of the metronome beat generator with tap tempo and a shared serial divider.
`timescale 1ns / 1ps
`default_nettype none
// Tick, start/stop, set tempo of zero and taps that set no tempo: result is registered at transfer.
// Set tempo: the beat period is computed with one restoring-divider step per cycle.
// Tap that sets the tempo: the tap quotient and then the period on the same divider.
// Throughput: one item per cycle unless the output stalls; input is held off during a division.
// A tick rate write keeps the input stalled while the period is recomputed.
// Synchronous active-low reset sets the state and configuration registers; divider data is not reset.
module metronome_beat_generator_core import mbg_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [7:0]        in_tdata,   // tempo_value[7:0]
  input  wire  [1:0]        in_tuser,   // opcode[1:0]
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [23:0]       out_tdata,  // beat, accent, pulse_ms[7:0], tempo_now[7:0], running,
                                        // beats_left[3:0], zero padding
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire  [ADDR_W-1:0] cfg_paddr,
  input  wire  [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  mbg_state_t state_r, state_nxt;

  logic [BAR_W-1:0]      bpb_r, bpb_nxt;
  logic [TICK_W-1:0]     tick_rate_r, tick_rate_nxt;
  logic [PULSE_W-1:0]    accent_ms_r, accent_ms_nxt;
  logic [PULSE_W-1:0]    beat_ms_r, beat_ms_nxt;

  logic [TIME_W-1:0]     tick_clock_r, tick_clock_nxt;
  logic [TIME_W-1:0]     last_beat_r, last_beat_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic [TEMPO_W-1:0]    tempo_r, tempo_nxt;
  logic [BAR_W-1:0]      counter_r, counter_nxt;
  logic                  started_r, started_nxt;
  logic [TIME_W-1:0]     last_tap_r, last_tap_nxt;
  logic                  tap_seen_r, tap_seen_nxt;

  logic [DIVISOR_W-1:0]  div_rem_r, div_rem_nxt;
  logic [DIVIDEND_W-1:0] div_quo_r, div_quo_nxt;
  logic [DIVISOR_W-1:0]  div_den_r, div_den_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  emit_r, emit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  mbg_result_t           out_res_r, out_res_nxt;

  mbg_op_t               op;
  logic [TEMPO_W-1:0]    tv;
  logic                  in_acc, cfg_wr, cfg_tr_wr;
  logic                  div_last, start_tap, start_set, start_cfg;
  logic [TIME_W-1:0]     clk_inc, elapsed, tap_delta;
  logic                  beat_hit, tap_ok;
  logic [BAR_W-1:0]      cnt_dec;
  logic [DIVISOR_W:0]    div_trial, div_diff;
  logic                  div_ge;
  logic [DIVISOR_W-1:0]  step_rem;
  logic [DIVIDEND_W-1:0] step_quo;
  logic [TEMPO_W-1:0]    tap_tempo;
  logic [DIVISOR_W-1:0]  tick_x3;

  assign op         = mbg_op_t'(in_tuser);
  assign tv         = in_tdata;
  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_tr_wr  = cfg_wr && (mbg_reg_t'(cfg_paddr[3:2]) == REG_TICK_RATE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

  assign clk_inc   = tick_clock_r + TIME_W'(1);
  assign elapsed   = clk_inc - last_beat_r;
  assign beat_hit  = started_r && (elapsed > TIME_W'(period_r));
  assign cnt_dec   = counter_r - BAR_W'(1);
  assign tap_delta = tick_clock_r - last_tap_r;
  assign tick_x3   = {1'b0, tick_rate_r, 1'b0} + DIVISOR_W'(tick_rate_r);
  assign tap_ok    = tap_seen_r && (tap_delta != '0) && (tap_delta < TIME_W'(tick_x3));

  assign div_last  = (div_cnt_r == DIV_CNT_W'(DIVIDEND_W - 1));
  assign start_tap = in_acc && (op == OP_TAP) && tap_ok;
  assign start_set = in_acc && (op == OP_SET) && (tv != '0);
  assign start_cfg = cfg_tr_wr && (tempo_r != '0);

  assign div_trial = {div_rem_r, div_quo_r[DIVIDEND_W-1]};
  assign div_diff  = div_trial - {1'b0, div_den_r};
  assign div_ge    = (div_trial >= {1'b0, div_den_r});
  assign step_rem  = div_ge ? div_diff[DIVISOR_W-1:0] : div_trial[DIVISOR_W-1:0];
  assign step_quo  = {div_quo_r[DIVIDEND_W-2:0], div_ge};
  assign tap_tempo = (step_quo > DIVIDEND_W'(TEMPO_MAX)) ? TEMPO_MAX : step_quo[TEMPO_W-1:0];

  always_comb begin
    unique case (mbg_reg_t'(cfg_paddr[3:2]))
      REG_BEATS_PER_BAR: cfg_prdata = {28'b0, bpb_r};
      REG_TICK_RATE:     cfg_prdata = {16'b0, tick_rate_r};
      REG_ACCENT_PULSE:  cfg_prdata = {24'b0, accent_ms_r};
      REG_BEAT_PULSE:    cfg_prdata = {24'b0, beat_ms_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    if (start_cfg) begin
      state_nxt = ST_PER_DIV;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start_tap) begin
            state_nxt = ST_TAP_DIV;
          end else if (start_set) begin
            state_nxt = ST_PER_DIV;
          end
        end
        ST_TAP_DIV: begin
          if (div_last) begin
            state_nxt = ST_PER_DIV;
          end
        end
        ST_PER_DIV: begin
          if (div_last) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    bpb_nxt        = bpb_r;
    tick_rate_nxt  = tick_rate_r;
    accent_ms_nxt  = accent_ms_r;
    beat_ms_nxt    = beat_ms_r;
    tick_clock_nxt = tick_clock_r;
    last_beat_nxt  = last_beat_r;
    period_nxt     = period_r;
    tempo_nxt      = tempo_r;
    counter_nxt    = counter_r;
    started_nxt    = started_r;
    last_tap_nxt   = last_tap_r;
    tap_seen_nxt   = tap_seen_r;
    div_rem_nxt    = step_rem;
    div_quo_nxt    = step_quo;
    div_den_nxt    = div_den_r;
    div_cnt_nxt    = div_cnt_r + DIV_CNT_W'(1);
    emit_nxt       = emit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_res_nxt    = out_res_r;

    if (cfg_wr) begin
      unique case (mbg_reg_t'(cfg_paddr[3:2]))
        REG_BEATS_PER_BAR: bpb_nxt       = cfg_pwdata[BAR_W-1:0];
        REG_TICK_RATE:     tick_rate_nxt = cfg_pwdata[TICK_W-1:0];
        REG_ACCENT_PULSE:  accent_ms_nxt = cfg_pwdata[PULSE_W-1:0];
        REG_BEAT_PULSE:    beat_ms_nxt   = cfg_pwdata[PULSE_W-1:0];
        default:           bpb_nxt       = bpb_r;
      endcase
    end

    if (in_acc) begin
      out_res_nxt.beat   = 1'b0;
      out_res_nxt.accent = 1'b0;
      out_res_nxt.pulse_ms = '0;
      unique case (op)
        OP_TICK: begin
          tick_clock_nxt = clk_inc;
          if (beat_hit) begin
            last_beat_nxt      = last_beat_r + TIME_W'(period_r);
            out_res_nxt.beat   = 1'b1;
            if (cnt_dec == '0) begin
              counter_nxt          = bpb_r;
              out_res_nxt.accent   = 1'b1;
              out_res_nxt.pulse_ms = accent_ms_r;
            end else begin
              counter_nxt          = cnt_dec;
              out_res_nxt.pulse_ms = beat_ms_r;
            end
          end
        end
        OP_TAP: begin
          last_tap_nxt = tick_clock_r;
          tap_seen_nxt = 1'b1;
        end
        OP_TOGGLE: begin
          started_nxt = !started_r;
          if (!started_r) begin
            last_beat_nxt = tick_clock_r;
            counter_nxt   = BAR_W'(1);
          end
        end
        OP_SET: begin
          if (tv != '0) begin
            tempo_nxt = tv;
          end
        end
        default: tempo_nxt = tempo_r;
      endcase
      out_res_nxt.tempo_now  = tempo_nxt;
      out_res_nxt.running    = started_nxt;
      out_res_nxt.beats_left = counter_nxt;
      out_valid_nxt          = !(start_tap || start_set);
    end

    if (start_cfg) begin
      div_rem_nxt = '0;
      div_quo_nxt = ticks_per_min(cfg_pwdata[TICK_W-1:0]);
      div_den_nxt = DIVISOR_W'(tempo_r);
      div_cnt_nxt = '0;
      emit_nxt    = 1'b0;
    end else if (start_tap || start_set) begin
      div_rem_nxt = '0;
      div_quo_nxt = ticks_per_min(tick_rate_r);
      div_den_nxt = start_tap ? tap_delta[DIVISOR_W-1:0] : DIVISOR_W'(tv);
      div_cnt_nxt = '0;
      emit_nxt    = 1'b1;
    end else if (state_r == ST_TAP_DIV && div_last) begin
      tempo_nxt   = tap_tempo;
      div_rem_nxt = '0;
      div_quo_nxt = ticks_per_min(tick_rate_r);
      div_den_nxt = DIVISOR_W'(tap_tempo);
      div_cnt_nxt = '0;
    end else if (state_r == ST_PER_DIV && div_last) begin
      period_nxt = step_quo;
      if (emit_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = '{beats_left: counter_r, running: started_r, tempo_now: tempo_r,
                          pulse_ms: '0, accent: 1'b0, beat: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bpb_r        <= RST_BEATS_PER_BAR;
      tick_rate_r  <= RST_TICK_RATE;
      accent_ms_r  <= RST_ACCENT_PULSE;
      beat_ms_r    <= RST_BEAT_PULSE;
      tick_clock_r <= '0;
      last_beat_r  <= '0;
      period_r     <= RST_PERIOD;
      tempo_r      <= RST_TEMPO;
      counter_r    <= BAR_W'(1);
      started_r    <= 1'b0;
      last_tap_r   <= '0;
      tap_seen_r   <= 1'b0;
      div_cnt_r    <= '0;
      emit_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bpb_r        <= bpb_nxt;
      tick_rate_r  <= tick_rate_nxt;
      accent_ms_r  <= accent_ms_nxt;
      beat_ms_r    <= beat_ms_nxt;
      tick_clock_r <= tick_clock_nxt;
      last_beat_r  <= last_beat_nxt;
      period_r     <= period_nxt;
      tempo_r      <= tempo_nxt;
      counter_r    <= counter_nxt;
      started_r    <= started_nxt;
      last_tap_r   <= last_tap_nxt;
      tap_seen_r   <= tap_seen_nxt;
      div_cnt_r    <= div_cnt_nxt;
      emit_r       <= emit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_den_r <= div_den_nxt;
    out_res_r <= out_res_nxt;
  end

  a_tempo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    tempo_r != '0) else $error("tempo register is zero");

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (div_den_r != '0)) else $error("divider runs with a zero divisor");

  a_tap_then_period: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAP_DIV && div_last) |=> (state_r == ST_PER_DIV))
    else $error("tap tempo division not followed by period recompute");

  a_out_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(in_acc) || $past(state_r == ST_PER_DIV && div_last)))
    else $error("result appeared without a transfer or a finished division");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && emit_r) |-> !out_valid_r)
    else $error("result pending while an item is still in the divider");

endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the metronome beat generator core, with a predicting scoreboard.
import mbg_pkg::*;

class beat_tracker;
  logic [3:0]  bar_len;
  logic [15:0] rate;
  logic [7:0]  accent_ms;
  logic [7:0]  plain_ms;
  logic [31:0] now;
  logic [31:0] last_beat;
  logic [31:0] period;
  logic [7:0]  tempo;
  logic [3:0]  bar_count;
  bit          started;
  logic [31:0] last_tap;
  bit          tap_seen;
  mbg_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned beats;
  int unsigned accents;
  int unsigned tap_tempos;

  function new();
    bar_len    = RST_BEATS_PER_BAR;
    rate       = RST_TICK_RATE;
    accent_ms  = RST_ACCENT_PULSE;
    plain_ms   = RST_BEAT_PULSE;
    now        = '0;
    last_beat  = '0;
    period     = 32'd512;
    tempo      = RST_TEMPO;
    bar_count  = 4'd1;
    started    = 1'b0;
    last_tap   = '0;
    tap_seen   = 1'b0;
    mismatches = 0;
    checked    = 0;
    beats      = 0;
    accents    = 0;
    tap_tempos = 0;
  endfunction

  function void refresh_period();
    if (tempo != 8'd0) period = (32'(rate) * 32'd60) / 32'(tempo);
  endfunction

  function void write_reg(mbg_reg_t idx, logic [31:0] val);
    case (idx)
      REG_BEATS_PER_BAR: bar_len = val[3:0];
      REG_TICK_RATE: begin
        rate = val[15:0];
        refresh_period();
      end
      REG_ACCENT_PULSE: accent_ms = val[7:0];
      REG_BEAT_PULSE: plain_ms = val[7:0];
    endcase
  endfunction

  function logic [31:0] reg_value(mbg_reg_t idx);
    case (idx)
      REG_BEATS_PER_BAR: return 32'(bar_len);
      REG_TICK_RATE: return 32'(rate);
      REG_ACCENT_PULSE: return 32'(accent_ms);
      default: return 32'(plain_ms);
    endcase
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  function void predict_item(mbg_op_t op, logic [7:0] tv);
    mbg_result_t r;
    logic [31:0] span;
    logic [31:0] quot;
    r = '0;
    case (op)
      OP_TICK: begin
        now = now + 32'd1;
        if (started) begin
          span = now - last_beat;
          if (span > period) begin
            last_beat = last_beat + period;
            bar_count = bar_count - 4'd1;
            r.beat = 1'b1;
            if (bar_count == 4'd0) begin
              bar_count  = bar_len;
              r.accent   = 1'b1;
              r.pulse_ms = accent_ms;
            end else begin
              r.pulse_ms = plain_ms;
            end
          end
        end
      end
      OP_TAP: begin
        span = now - last_tap;
        if (tap_seen && span != 32'd0 && span < 32'(rate) * 32'd3) begin
          quot  = (32'(rate) * 32'd60) / span;
          tempo = (quot > 32'd255) ? TEMPO_MAX : quot[7:0];
          refresh_period();
          tap_tempos++;
        end
        last_tap = now;
        tap_seen = 1'b1;
      end
      OP_TOGGLE: begin
        started = !started;
        if (started) begin
          last_beat = now;
          bar_count = 4'd1;
        end
      end
      OP_SET: begin
        if (tv != 8'd0) begin
          tempo = tv;
          refresh_period();
        end
      end
    endcase
    r.tempo_now  = tempo;
    r.running    = started;
    r.beats_left = bar_count;
    pending_results.push_back(r);
  endfunction

  function void compare_result(logic [23:0] word);
    mbg_result_t got;
    mbg_result_t want;
    got = mbg_result_t'(word[22:0]);
    if (pending_results.size() == 0) begin
      flag($sformatf("result %h arrived with nothing pending", word));
      return;
    end
    want = pending_results.pop_front();
    checked++;
    if (want.beat) beats++;
    if (want.accent) accents++;
    if (got.beat !== want.beat || got.accent !== want.accent ||
        got.pulse_ms !== want.pulse_ms || got.tempo_now !== want.tempo_now ||
        got.running !== want.running || got.beats_left !== want.beats_left ||
        word[23] !== 1'b0) begin
      flag($sformatf({"result %0d: expected beat=%b accent=%b pulse=%0d tempo=%0d run=%b ",
                      "left=%0d, got beat=%b accent=%b pulse=%0d tempo=%0d run=%b left=%0d pad=%b"},
                     checked, want.beat, want.accent, want.pulse_ms, want.tempo_now,
                     want.running, want.beats_left, got.beat, got.accent, got.pulse_ms,
                     got.tempo_now, got.running, got.beats_left, word[23]));
    end
  endfunction
endclass

module testbench;
  localparam int unsigned CYCLE_LIMIT       = 500000;
  localparam int unsigned SETTINGS_COUNT    = 10;
  localparam int unsigned ITEMS_PER_SETTING = 140;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic [7:0]        in_tdata    = '0;
  logic [1:0]        in_tuser    = '0;
  logic              out_tready  = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  wire               in_tready;
  wire               out_tvalid;
  wire  [23:0]       out_tdata;
  wire  [31:0]       cfg_prdata;
  wire               cfg_pready;

  beat_tracker sb;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned settings_run = 0;
  rx_mode_t    rx_mode    = RX_OPEN;
  int unsigned rx_hold    = 0;
  int unsigned rx_stall   = 0;
  logic        rx_ready;

  always #10 clk = ~clk;

  metronome_beat_generator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.compare_result(out_tdata);
      if (in_tvalid && in_tready) sb.predict_item(mbg_op_t'(in_tuser), in_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d results outstanding",
               sb.pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_hold = $urandom_range(50, 400);
    end else begin
      rx_hold = rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN: rx_ready = 1'b1;
      RX_COIN: rx_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_ready = ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall != 0) begin
          rx_ready = 1'b0;
          rx_stall = rx_stall - 1;
        end else begin
          rx_ready = 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 12);
        end
      end
    endcase
    out_tready <= rx_ready;
  end

  task automatic send_item(input mbg_op_t op, input logic [7:0] tv);
    int unsigned idle;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      idle = $urandom_range(1, 10);
      repeat (idle) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tv;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic cfg_write(input mbg_reg_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(input mbg_reg_t idx);
    logic [31:0] want;
    want = sb.reg_value(idx);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      sb.flag($sformatf("register %s reads %h, expected %h", idx.name(), cfg_prdata, want));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] bars, input logic [15:0] rate,
                               input logic [7:0] accent, input logic [7:0] plain);
    drain_results();
    cfg_write(REG_BEATS_PER_BAR, 32'(bars));
    cfg_write(REG_ACCENT_PULSE, 32'(accent));
    cfg_write(REG_BEAT_PULSE, 32'(plain));
    cfg_write(REG_TICK_RATE, 32'(rate));
    for (int i = 0; i < 4; i++) cfg_check(mbg_reg_t'(i));
    settings_run++;
  endtask

  task automatic send_random();
    int unsigned pick;
    int unsigned toggle_odds;
    logic [7:0]  tv;
    pick = $urandom_range(0, 99);
    toggle_odds = sb.started ? 2 : 20;
    tv = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(40, 220));
    if (pick < toggle_odds) send_item(OP_TOGGLE, 8'($urandom));
    else if (pick < toggle_odds + 12) send_item(OP_TAP, 8'($urandom));
    else if (pick < toggle_odds + 22) send_item(OP_SET, tv);
    else send_item(OP_TICK, 8'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < 4; i++) cfg_check(mbg_reg_t'(i));

    apply_setting(4'd2, 16'd8, 8'd255, 8'd0);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TAP, 8'h00);
    send_item(OP_TAP, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TAP, 8'h00);
    send_item(OP_SET, 8'd0);
    send_item(OP_TOGGLE, 8'h00);
    repeat (4) send_item(OP_TICK, 8'h00);
    send_item(OP_SET, 8'd255);
    send_item(OP_SET, 8'd40);
    repeat (3) send_item(OP_TICK, 8'hFF);
    send_item(OP_TAP, 8'hFF);
    send_item(OP_TOGGLE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TOGGLE, 8'h00);
    send_item(OP_SET, 8'd1);
    send_item(OP_SET, 8'd220);
    send_item(OP_TICK, 8'h00);

    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      case (p)
        0: apply_setting(4'd4, 16'd8, 8'd90, 8'd30);
        1: apply_setting(4'd1, 16'd4, 8'd0, 8'd255);
        2: apply_setting(4'd9, 16'd6, 8'd255, 8'd0);
        3: apply_setting(4'd0, 16'd5, 8'($urandom), 8'($urandom));
        4: apply_setting(4'd15, 16'd3, 8'($urandom), 8'($urandom));
        5: apply_setting(4'd3, 16'd0, 8'($urandom), 8'($urandom));
        6: apply_setting(4'd2, 16'd65535, 8'($urandom), 8'($urandom));
        7: apply_setting(4'd2, 16'd1, 8'($urandom), 8'($urandom));
        default: apply_setting(4'($urandom_range(1, 9)), 16'($urandom_range(2, 40)),
                               8'($urandom), 8'($urandom));
      endcase
      for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
        if (p == 0 && k == ITEMS_PER_SETTING / 2) drain_results();
        send_random();
      end
    end

    drain_results();
    $display("%0d items sent under %0d register settings, %0d results checked",
             items_sent, settings_run, sb.checked);
    $display("%0d beats of which %0d accents, %0d tempo changes from taps",
             sb.beats, sb.accents, sb.tap_tempos);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
